### src/emp_pkg.sv
// Package for the encoder motor position controller.
// Holds request kind codes, register indexes, widths and reset values.
// No dependencies.
package emp_pkg;

    typedef enum logic [2:0] {
        KIND_EDGE   = 3'd0,
        KIND_SPIN   = 3'd1,
        KIND_FOLLOW = 3'd2,
        KIND_SPEED  = 3'd3,
        KIND_TARGET = 3'd4,
        KIND_CLEAR  = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        REG_INVERT   = 3'd0,
        REG_GAIN     = 3'd1,
        REG_LIMIT    = 3'd2,
        REG_PERIOD   = 3'd3,
        REG_DIVISOR  = 3'd4
    } t_reg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int POS_W      = 32;
    localparam int SPEED_W    = 8;
    localparam int DIV_W      = 16;
    localparam int QUO_W      = POS_W + 1;
    localparam int CNT_W      = $clog2(QUO_W);

    localparam logic [7:0]  DRIVE_MAX     = 8'd255;
    localparam logic [7:0]  GAIN_RESET    = 8'd1;
    localparam logic [6:0]  LIMIT_RESET   = 7'd10;
    localparam logic [15:0] PERIOD_RESET  = 16'd10;
    localparam logic [15:0] DIVISOR_RESET = 16'd4;

endpackage

### src/encoder_motor_position_controller.sv
// Encoder motor position controller: proportional position loop with
// encoder counter, timed setpoint advance and serial follow-speed divider.
// Depends on emp_pkg.
//
// Usage:
//   Input channel (i_valid/o_ready) carries one request: encoder edge, spin
//   step, follow step, set speed, set target or clear. Each request gives
//   exactly one result on the output channel (o_valid/i_ready): direction,
//   PWM, moving flag and the position after the request.
//   Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data); the user
//   writes it only while no request is in flight, as the block does not enforce it.
// Sequencing:
//   Most requests pass S_EXEC, then S_DONE, which loads the output register behind o_valid.
//   A follow step passes S_EXEC, S_DIV and S_FIN before S_DONE; in S_DIV
//   the signed target error is divided by the follow divisor in a restoring
//   divider that produces one quotient bit per cycle (33 bits).
//   One request is in flight at a time; o_ready is high only when idle.
// Reset:
//   Synchronous, active low. Position, setpoint, speeds, timer and target
//   return to zero; registers return to their reset values.
// Stall:
//   The result sits in an output register; a new request is accepted while it
//   waits, and a finished result holds, with o_ready low, until it frees.
module encoder_motor_position_controller
    import emp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [2:0]              i_kind,
    input  logic                    i_enc_b,
    input  logic signed [31:0]      i_value,
    input  logic [31:0]             i_now_ms,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_backward,
    output logic [7:0]              o_pwm,
    output logic                    o_moving,
    output logic signed [31:0]      o_position_now
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_FIN,
        S_DONE
    } t_state;

    t_state r_state;

    logic        r_invert;
    logic [7:0]  r_gain;
    logic [6:0]  r_limit;
    logic [15:0] r_period;
    logic [15:0] r_divisor;

    logic [POS_W-1:0]   r_position;
    logic [POS_W-1:0]   r_setpoint;
    logic [SPEED_W-1:0] r_speed_now;
    logic [SPEED_W-1:0] r_speed_cmd;
    logic [31:0]        r_advance;
    logic [POS_W-1:0]   r_target;

    logic [2:0]  r_kind;
    logic        r_enc_b;
    logic [31:0] r_value;
    logic [31:0] r_now;

    logic [DIV_W-1:0] r_rem;
    logic [QUO_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_qneg;

    logic       r_res_bwd;
    logic [7:0] r_res_pwm;
    logic       r_res_moving;

    logic              r_out_valid;
    logic              r_out_bwd;
    logic [7:0]        r_out_pwm;
    logic              r_out_moving;
    logic [POS_W-1:0]  r_out_pos;

    logic [QUO_W-1:0] err;
    logic [QUO_W-1:0] err_mag;
    logic [15:0]      prod;
    logic             drive_neg;
    logic [7:0]       drive_pwm;
    logic             timer_hit;
    logic [QUO_W-1:0] terr;
    logic [DIV_W-1:0] div_eff;
    logic [DIV_W:0]   rem_sh;
    logic             rem_ge;
    logic [DIV_W:0]   rem_sub;
    logic [7:0]       lim;
    logic             q_over;
    logic [7:0]       q_mag;
    logic signed [31:0] lim32;
    logic [7:0]       spd_clamped;

    assign err       = {r_setpoint[POS_W-1], r_setpoint} - {r_position[POS_W-1], r_position};
    assign err_mag   = err[QUO_W-1] ? (~err + 1'b1) : err;
    assign prod      = r_gain * err_mag[7:0];
    assign drive_neg = err[QUO_W-1] && (r_gain != 8'd0);
    assign drive_pwm = (r_gain == 8'd0) ? 8'd0 :
                       ((|err_mag[QUO_W-1:8]) || (|prod[15:8])) ? DRIVE_MAX : prod[7:0];
    assign timer_hit = r_now > r_advance;

    assign terr    = {r_target[POS_W-1], r_target} - {r_position[POS_W-1], r_position};
    assign div_eff = (r_divisor == '0) ? DIV_W'(1) : r_divisor;
    assign rem_sh  = {r_rem, r_quo[QUO_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, div_eff};
    assign rem_sub = rem_sh - {1'b0, div_eff};

    assign lim    = r_speed_cmd[SPEED_W-1] ? (~r_speed_cmd + 1'b1) : r_speed_cmd;
    assign q_over = (|r_quo[QUO_W-1:8]) || (r_quo[7:0] > lim);
    assign q_mag  = q_over ? lim : r_quo[7:0];

    assign lim32 = signed'({25'd0, r_limit});
    always_comb begin
        if (signed'(r_value) > lim32) begin
            spd_clamped = {1'b0, r_limit};
        end else if (signed'(r_value) < -lim32) begin
            spd_clamped = ~{1'b0, r_limit} + 1'b1;
        end else begin
            spd_clamped = r_value[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_invert     <= 1'b0;
            r_gain       <= GAIN_RESET;
            r_limit      <= LIMIT_RESET;
            r_period     <= PERIOD_RESET;
            r_divisor    <= DIVISOR_RESET;
            r_position   <= '0;
            r_setpoint   <= '0;
            r_speed_now  <= '0;
            r_speed_cmd  <= '0;
            r_advance    <= '0;
            r_target     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_INVERT:  r_invert  <= i_cfg_data[0];
                    REG_GAIN:    r_gain    <= i_cfg_data[7:0];
                    REG_LIMIT:   r_limit   <= i_cfg_data[6:0];
                    REG_PERIOD:  r_period  <= i_cfg_data;
                    REG_DIVISOR: r_divisor <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind  <= i_kind;
                        r_enc_b <= i_enc_b;
                        r_value <= i_value;
                        r_now   <= i_now_ms;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res_moving <= 1'b0;
                    if (r_kind inside {KIND_SPIN, KIND_FOLLOW}) begin
                        r_res_bwd <= drive_neg ^ r_invert;
                        r_res_pwm <= drive_pwm;
                    end else begin
                        r_res_bwd <= 1'b0;
                        r_res_pwm <= '0;
                    end
                    r_state <= (r_kind == KIND_FOLLOW) ? S_DIV : S_DONE;
                    case (r_kind)
                        KIND_EDGE: begin
                            if (r_enc_b ^ r_invert) begin
                                r_position <= r_position + 1'b1;
                            end else begin
                                r_position <= r_position - 1'b1;
                            end
                        end
                        KIND_SPIN, KIND_FOLLOW: begin
                            if (timer_hit) begin
                                r_advance  <= r_now + {16'd0, r_period};
                                r_setpoint <= r_setpoint
                                              + {{(POS_W-SPEED_W){r_speed_now[SPEED_W-1]}},
                                                 r_speed_now};
                            end
                            if (r_kind == KIND_FOLLOW) begin
                                r_qneg  <= terr[QUO_W-1];
                                r_quo   <= terr[QUO_W-1] ? (~terr + 1'b1) : terr;
                                r_rem   <= '0;
                                r_cnt   <= '0;
                            end
                        end
                        KIND_SPEED: begin
                            r_speed_now <= spd_clamped;
                            r_speed_cmd <= spd_clamped;
                        end
                        KIND_TARGET: begin
                            r_target <= r_value;
                        end
                        KIND_CLEAR: begin
                            r_position  <= '0;
                            r_setpoint  <= '0;
                            r_speed_now <= '0;
                            r_speed_cmd <= '0;
                            r_advance   <= '0;
                            r_target    <= '0;
                        end
                        default: ;
                    endcase
                end
                S_DIV: begin
                    r_rem <= rem_ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
                    r_quo <= {r_quo[QUO_W-2:0], rem_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(QUO_W - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_speed_now  <= r_qneg ? (~q_mag + 1'b1) : q_mag;
                    r_res_moving <= |r_quo;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_bwd    <= r_res_bwd;
                        r_out_pwm    <= r_res_pwm;
                        r_out_moving <= r_res_moving;
                        r_out_pos    <= r_position;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_backward     = r_out_bwd;
    assign o_pwm          = r_out_pwm;
    assign o_moving       = r_out_moving;
    assign o_position_now = r_out_pos;

endmodule
